### design/sorted_priority_queue_unit_defines.svh
// Assertion macros shared by the sorted priority queue RTL.
// Files that use them need signals named clk and rst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Property that must hold in the cycle after a trigger condition.
`define SPQ_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### design/spq_pkg.sv
// Types and constants of the sorted priority queue.
// Used by spq_cell and sorted_priority_queue_unit; depends on nothing.
package spq_pkg;

    localparam int PRIO_W     = 16;
    localparam int TAG_PORT_W = 64;
    localparam int POS_W      = 5;

    typedef enum logic [1:0] {
        FN_INSERT  = 2'd0,
        FN_DEQUEUE = 2'd1,
        FN_FIND    = 2'd2,
        FN_DELETE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Per-cycle command broadcast to every cell; already gated by the request fire.
    typedef struct packed {
        logic                     ins;
        logic                     deq;
        logic                     del;
        logic signed [PRIO_W-1:0] prio;
    } spq_ctrl_t;

    // Flags handed from one cell to the next one toward the tail.
    typedef struct packed {
        logic ge;   // this cell holds an entry of equal or higher priority
        logic hit;  // a tag match exists at this cell or nearer the head
    } spq_link_t;

endpackage

### design/spq_cell.sv
// One storage cell of the sorted priority queue chain.
// Depends on spq_pkg for the command and link types.
module spq_cell
    import spq_pkg::*;
#(
    parameter int TAG_BITS = 64
) (
    input  logic                       clk,
    input  spq_ctrl_t                  ctrl,
    input  logic [TAG_BITS-1:0]        key_tag,
    input  logic                       occupied,
    input  spq_link_t                  link_in,
    output spq_link_t                  link_out,
    output logic                       first,
    input  logic [TAG_BITS-1:0]        left_tag,
    input  logic signed [PRIO_W-1:0]   left_prio,
    input  logic [TAG_BITS-1:0]        right_tag,
    input  logic signed [PRIO_W-1:0]   right_prio,
    output logic [TAG_BITS-1:0]        ent_tag,
    output logic signed [PRIO_W-1:0]   ent_prio
);

    logic [TAG_BITS-1:0]      tag_reg;
    logic [TAG_BITS-1:0]      tag_next;
    logic signed [PRIO_W-1:0] prio_reg;
    logic signed [PRIO_W-1:0] prio_next;
    logic                     ge;
    logic                     match;

    always_comb
    begin
        ge           = occupied && ($signed(prio_reg) >= $signed(ctrl.prio));
        match        = occupied && (tag_reg == key_tag);
        link_out.ge  = ge;
        link_out.hit = link_in.hit | match;
        first        = match & ~link_in.hit;

        tag_next  = tag_reg;
        prio_next = prio_reg;
        if (ctrl.ins)
        begin
            // The first cell whose entry ranks below the new one takes it;
            // every cell behind that one moves one place toward the tail.
            if (!ge)
            begin
                if (link_in.ge)
                begin
                    tag_next  = key_tag;
                    prio_next = ctrl.prio;
                end
                else
                begin
                    tag_next  = left_tag;
                    prio_next = left_prio;
                end
            end
        end
        else if (ctrl.deq || (ctrl.del && link_out.hit))
        begin
            tag_next  = right_tag;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

    assign ent_tag  = tag_reg;
    assign ent_prio = prio_reg;

endmodule

### design/sorted_priority_queue_unit.sv
// Sorted priority queue: top level with request and result registers.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_unit_defines.svh.
//
// Usage: a request (func, tag, prio) is taken when in_valid is high and
// in_stall is low. func selects insert, dequeue of the head, find by tag or
// delete by tag. Every request gives exactly one result (status, out_tag,
// out_prio, position), offered with out_valid until out_stall is low.
// Entries are held in a chain of DEPTH cells in descending priority order;
// an insert lands behind all entries of equal or higher priority.
// The result is registered when the request fires. Throughput: one request
// per cycle while out_stall is low, because every cell compares its entry
// against the request and shifts to a neighbor in the same cycle. A request
// is held in the request register until the result register is free; while
// a result waits under out_stall, one more request is taken and then
// in_stall rises. Reset empties the queue and drops any pending request or
// result; no clearing pass is needed.
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int TAG_BITS = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                func,
    input  logic [TAG_PORT_W-1:0]     tag,
    input  logic signed [PRIO_W-1:0]  prio,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic [TAG_PORT_W-1:0]     out_tag,
    output logic signed [PRIO_W-1:0]  out_prio,
    output logic [POS_W-1:0]          position
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                     req_valid_reg;
    logic                     req_valid_next;
    func_t                    func_reg;
    logic [TAG_BITS-1:0]      tag_reg;
    logic signed [PRIO_W-1:0] prio_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [TAG_BITS-1:0]      out_tag_reg;
    logic [TAG_BITS-1:0]      out_tag_next;
    logic signed [PRIO_W-1:0] out_prio_reg;
    logic signed [PRIO_W-1:0] out_prio_next;
    logic [POS_W-1:0]         position_reg;
    logic [POS_W-1:0]         position_next;

    logic                     fire;
    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     any_hit;
    spq_ctrl_t                ctrl;
    logic [TAG_BITS-1:0]      sel_tag;
    logic signed [PRIO_W-1:0] sel_prio;
    logic [POS_W-1:0]         sel_pos;

    logic [TAG_BITS-1:0]      cell_tag  [DEPTH];
    logic signed [PRIO_W-1:0] cell_prio [DEPTH];
    logic [DEPTH-1:0]         first_vec;
    logic [DEPTH-1:0]         occ_vec;
    spq_link_t                link_w    [DEPTH+1];

    assign fire     = req_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign any_hit  = link_w[DEPTH].hit;

    always_comb
    begin
        ctrl.ins  = fire && (func_reg == FN_INSERT) && !full;
        ctrl.deq  = fire && (func_reg == FN_DEQUEUE) && !empty;
        ctrl.del  = fire && (func_reg == FN_DELETE);
        ctrl.prio = prio_reg;
    end

    assign link_w[0] = '{ge: 1'b1, hit: 1'b0};

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [TAG_BITS-1:0]      l_tag;
        logic signed [PRIO_W-1:0] l_prio;
        logic [TAG_BITS-1:0]      r_tag;
        logic signed [PRIO_W-1:0] r_prio;

        assign occ_vec[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign l_tag  = '0;
            assign l_prio = '0;
        end
        else
        begin : g_body
            assign l_tag  = cell_tag[i-1];
            assign l_prio = cell_prio[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign r_tag  = '0;
            assign r_prio = '0;
        end
        else
        begin : g_inner
            assign r_tag  = cell_tag[i+1];
            assign r_prio = cell_prio[i+1];
        end

        spq_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .key_tag    (tag_reg),
            .occupied   (occ_vec[i]),
            .link_in    (link_w[i]),
            .link_out   (link_w[i+1]),
            .first      (first_vec[i]),
            .left_tag   (l_tag),
            .left_prio  (l_prio),
            .right_tag  (r_tag),
            .right_prio (r_prio),
            .ent_tag    (cell_tag[i]),
            .ent_prio   (cell_prio[i])
        );
    end

    // At most one cell flags the first match, so an OR over the cells selects it.
    always_comb
    begin
        sel_tag  = '0;
        sel_prio = '0;
        sel_pos  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_tag  = sel_tag | (cell_tag[i] & {TAG_BITS{first_vec[i]}});
            sel_prio = sel_prio | (cell_prio[i] & {PRIO_W{first_vec[i]}});
            sel_pos  = sel_pos | (POS_W'(i + 1) & {POS_W{first_vec[i]}});
        end
    end

    always_comb
    begin
        status_next   = ST_OK;
        out_tag_next  = '0;
        out_prio_next = '0;
        position_next = '0;
        unique case (func_reg)
            FN_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
            end
            FN_DEQUEUE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    out_tag_next  = cell_tag[0];
                    out_prio_next = cell_prio[0];
                end
            end
            FN_FIND:
            begin
                if (any_hit)
                begin
                    out_tag_next  = sel_tag;
                    out_prio_next = sel_prio;
                    position_next = sel_pos;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            FN_DELETE:
            begin
                if (!any_hit)
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.deq || (ctrl.del && any_hit))
        begin
            count_next = count_reg - 1'b1;
        end

        req_valid_next = req_valid_reg;
        if (accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (fire)
        begin
            req_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(func);
            tag_reg  <= tag[TAG_BITS-1:0];
            prio_reg <= prio;
        end
        if (fire)
        begin
            status_reg   <= status_next;
            out_tag_reg  <= out_tag_next;
            out_prio_reg <= out_prio_next;
            position_reg <= position_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_tag   = TAG_PORT_W'(out_tag_reg);
    assign out_prio  = out_prio_reg;
    assign position  = position_reg;

    `SPQ_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "entry count exceeds capacity")
    `SPQ_ASSERT(a_single_first, $onehot0(first_vec), "more than one cell claims the first match")
    `SPQ_ASSERT_NEXT(a_insert_grows, ctrl.ins, count_reg == CNT_W'($past(count_reg) + 1'b1), "insert did not grow the queue by one")
    `SPQ_ASSERT_NEXT(a_delete_shrinks, ctrl.del && any_hit, count_reg == CNT_W'($past(count_reg) - 1'b1), "delete did not shrink the queue by one")

endmodule

### test/tb_sorted_priority_queue_unit.sv
// Self-checking testbench for sorted_priority_queue_unit.
// Needs spq_pkg and the queue RTL; an in-bench priority queue predicts each result
// while bursty requests and a patterned result stall exercise the handshakes.
`timescale 1ns / 100ps

module tb_sorted_priority_queue_unit;
    import spq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int TAG_BITS       = 64;
    localparam int RANDOM_REQS    = 850;
    localparam int POOL_SIZE      = 20;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int MAX_PRINTS     = 40;
    localparam logic [TAG_PORT_W-1:0] TAG_MASK =
        (TAG_BITS >= TAG_PORT_W) ? '1 : ((64'd1 << TAG_BITS) - 64'd1);

    typedef struct packed {
        func_t                    op;
        logic [TAG_PORT_W-1:0]    tag;
        logic signed [PRIO_W-1:0] prio;
    } queue_req_t;

    typedef struct packed {
        status_t                  st;
        logic [TAG_PORT_W-1:0]    tag;
        logic signed [PRIO_W-1:0] prio;
        logic [POS_W-1:0]         pos;
    } queue_res_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [1:0]               func      = FN_INSERT;
    logic [TAG_PORT_W-1:0]    tag       = '0;
    logic signed [PRIO_W-1:0] prio      = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               status;
    logic [TAG_PORT_W-1:0]    out_tag;
    logic signed [PRIO_W-1:0] out_prio;
    logic [POS_W-1:0]         position;

    // Shadow copy of the stored entries, head at index 0.
    logic [TAG_PORT_W-1:0]    shadow_tag  [DEPTH];
    logic signed [PRIO_W-1:0] shadow_prio [DEPTH];
    int                       shadow_count;

    queue_req_t req_backlog [$];
    queue_res_t results_due [$];
    logic [TAG_PORT_W-1:0] tag_pool [POOL_SIZE];

    int mismatch_count;
    int accepted_count;
    int cycle_count;
    int peak_fill;
    int input_held_cycles;
    int op_count     [4];
    int status_count [4];
    int burst_left;
    int gap_left;
    int stall_style;
    int style_left;
    int holdoff_left;
    int holdoffs_done;

    sorted_priority_queue_unit #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .tag       (tag),
        .prio      (prio),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .out_tag   (out_tag),
        .out_prio  (out_prio),
        .position  (position)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        // Keep the log bounded when the block is badly broken.
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int locate_tag(input logic [TAG_PORT_W-1:0] t);
        int i;
        for (i = 0; i < shadow_count; i++)
        begin
            if (shadow_tag[i] == t)
                return i;
        end
        return -1;
    endfunction

    function automatic void remove_entry(input int k);
        int i;
        for (i = k; i + 1 < shadow_count; i++)
        begin
            shadow_tag[i]  = shadow_tag[i + 1];
            shadow_prio[i] = shadow_prio[i + 1];
        end
        shadow_count--;
    endfunction

    // Applies one request to the shadow queue and returns the result it must give.
    function automatic queue_res_t serve_request(input queue_req_t r);
        queue_res_t            res;
        logic [TAG_PORT_W-1:0] t;
        int                    slot;
        int                    i;
        int                    k;
        res = '{st: ST_OK, tag: '0, prio: '0, pos: '0};
        t   = r.tag & TAG_MASK;
        case (r.op)
            FN_INSERT:
            begin
                if (shadow_count >= DEPTH)
                    res.st = ST_FULL;
                else
                begin
                    slot = 0;
                    while (slot < shadow_count && shadow_prio[slot] >= r.prio)
                        slot++;
                    for (i = shadow_count; i > slot; i--)
                    begin
                        shadow_tag[i]  = shadow_tag[i - 1];
                        shadow_prio[i] = shadow_prio[i - 1];
                    end
                    shadow_tag[slot]  = t;
                    shadow_prio[slot] = r.prio;
                    shadow_count++;
                end
            end
            FN_DEQUEUE:
            begin
                if (shadow_count == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    res.tag  = shadow_tag[0];
                    res.prio = shadow_prio[0];
                    remove_entry(0);
                end
            end
            FN_FIND:
            begin
                k = locate_tag(t);
                if (k < 0)
                    res.st = ST_NOT_FOUND;
                else
                begin
                    res.tag  = shadow_tag[k];
                    res.prio = shadow_prio[k];
                    res.pos  = POS_W'(k + 1);
                end
            end
            default:
            begin
                k = locate_tag(t);
                if (k < 0)
                    res.st = ST_NOT_FOUND;
                else
                    remove_entry(k);
            end
        endcase
        return res;
    endfunction

    task automatic queue_request(input func_t op, input logic [TAG_PORT_W-1:0] t,
                                 input logic signed [PRIO_W-1:0] p);
        req_backlog.push_back('{op: op, tag: t, prio: p});
    endtask

    // Request driver: bursts of random length with random gaps in between.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        queue_req_t cur;
        queue_res_t due;
        logic       take_next;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            func       <= FN_INSERT;
            tag        <= '0;
            prio       <= '0;
            burst_left  = 1;
            gap_left    = 0;
        end
        else
        begin
            take_next = !in_valid;
            if (in_valid && !in_stall)
            begin
                cur = '{op: func_t'(func), tag: tag, prio: prio};
                due = serve_request(cur);
                results_due.push_back(due);
                accepted_count++;
                op_count[cur.op]++;
                status_count[due.st]++;
                if (shadow_count > peak_fill)
                    peak_fill = shadow_count;
                take_next = 1'b1;
            end
            if (take_next)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (req_backlog.size() > 0)
                begin
                    cur = req_backlog.pop_front();
                    in_valid <= 1'b1;
                    func     <= cur.op;
                    tag      <= cur.tag;
                    prio     <= cur.prio;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(24, 1);
                        gap_left   = ($urandom_range(99, 0) < 30) ? 0 : $urandom_range(8, 1);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result stall: changing patterns, plus two long hold-offs that back the block up.
    always @(posedge clk or negedge rst_n)
    begin : stall_proc
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            stall_style   = 0;
            style_left    = 0;
            holdoff_left  = 0;
            holdoffs_done = 0;
        end
        else
        begin
            if (holdoff_left == 0 && holdoffs_done < 2 &&
                accepted_count >= 300 * (holdoffs_done + 1))
            begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoffs_done++;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (style_left == 0)
                begin
                    stall_style = $urandom_range(3, 0);
                    style_left  = $urandom_range(60, 10);
                end
                style_left--;
                case (stall_style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(99, 0) < 25);
                    2:       out_stall <= ($urandom_range(99, 0) < 70);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin : monitor_proc
        queue_res_t due;
        if (rst_n)
        begin
            if (in_valid && in_stall)
                input_held_cycles++;
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                    flag_mismatch($sformatf("result status=%0d with no request pending",
                                            status));
                else
                begin
                    due = results_due.pop_front();
                    if (status != due.st)
                        flag_mismatch($sformatf("status %0d, expected %0d", status, due.st));
                    if (out_tag != due.tag)
                        flag_mismatch($sformatf("out_tag %h, expected %h", out_tag, due.tag));
                    if (out_prio != due.prio)
                        flag_mismatch($sformatf("out_prio %0d, expected %0d",
                                                out_prio, due.prio));
                    if (position != due.pos)
                        flag_mismatch($sformatf("position %0d, expected %0d",
                                                position, due.pos));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_due.size());
            $display("** sorted_priority_queue_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus_proc
        int                       made;
        int                       mode;
        int                       run_len;
        int                       j;
        int                       r;
        func_t                    op;
        logic [TAG_PORT_W-1:0]    t;
        logic signed [PRIO_W-1:0] p;

        for (j = 0; j < POOL_SIZE; j++)
            tag_pool[j] = {$urandom, $urandom};

        // Empty-queue cases first.
        queue_request(FN_DEQUEUE, '0, '0);
        queue_request(FN_FIND, '1, 16'sd7);
        queue_request(FN_DELETE, '0, '0);
        // Fill to capacity with extreme tags, extreme priorities and ties.
        queue_request(FN_INSERT, '0, 16'sd0);
        queue_request(FN_INSERT, '1, 16'sd32767);
        queue_request(FN_INSERT, tag_pool[0], -16'sd32768);
        queue_request(FN_INSERT, tag_pool[1], 16'sd0);
        queue_request(FN_INSERT, tag_pool[2], 16'sd32767);
        queue_request(FN_INSERT, tag_pool[3], -16'sd32768);
        for (j = 4; j < 14; j++)
            queue_request(FN_INSERT, tag_pool[j], PRIO_W'(int'($urandom_range(6, 0)) - 3));
        // Insert into a full queue is dropped.
        queue_request(FN_INSERT, tag_pool[14], 16'sd1);
        // The last tie at the lowest priority sits at the tail.
        queue_request(FN_FIND, tag_pool[3], '0);
        queue_request(FN_FIND, 64'hA5A5_5A5A_0F0F_F0F0, '0);
        queue_request(FN_DELETE, '0, '0);
        queue_request(FN_DEQUEUE, '0, '0);
        queue_request(FN_DELETE, 64'h0123_4567_89AB_CDEF, '0);

        // Random part: runs that lean toward filling, draining or a mix.
        made = 0;
        while (made < RANDOM_REQS)
        begin
            mode    = $urandom_range(2, 0);
            run_len = $urandom_range(40, 8);
            for (j = 0; j < run_len; j++)
            begin
                r = $urandom_range(99, 0);
                case (mode)
                    0:       op = (r < 65) ? FN_INSERT : (r < 75) ? FN_DEQUEUE :
                                  (r < 90) ? FN_FIND : FN_DELETE;
                    1:       op = (r < 15) ? FN_INSERT : (r < 60) ? FN_DEQUEUE :
                                  (r < 80) ? FN_FIND : FN_DELETE;
                    default: op = func_t'(r % 4);
                endcase
                if ($urandom_range(99, 0) < 80)
                    t = tag_pool[$urandom_range(POOL_SIZE - 1, 0)];
                else
                    t = {$urandom, $urandom};
                r = $urandom_range(99, 0);
                if (r < 35)
                    p = PRIO_W'(int'($urandom_range(4, 0)) - 2);
                else if (r < 45)
                    p = $urandom_range(1, 0) ? 16'sd32767 : -16'sd32768;
                else
                    p = PRIO_W'($urandom);
                queue_request(op, t, p);
                made++;
            end
        end

        while (!rst_n || req_backlog.size() != 0 || in_valid)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        // Give a stray extra result time to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (results_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", results_due.size()));

        $display("%0d requests (%0d ins, %0d deq, %0d find, %0d del), fill peaked at %0d of %0d",
                 accepted_count, op_count[FN_INSERT], op_count[FN_DEQUEUE],
                 op_count[FN_FIND], op_count[FN_DELETE], peak_fill, DEPTH);
        $display("%0d ok, %0d empty, %0d not found, %0d full; held %0d cycles, %0d mismatches",
                 status_count[ST_OK], status_count[ST_EMPTY], status_count[ST_NOT_FOUND],
                 status_count[ST_FULL], input_held_cycles, mismatch_count);
        if (mismatch_count == 0)
            $display("** sorted_priority_queue_unit: PASSED **");
        else
            $display("** sorted_priority_queue_unit: FAILED **");
        $finish;
    end

endmodule
